### rtl/core/rd64_pkg.sv
`timescale 1ns / 1ps

package rd64_pkg;

  // width of every payload field on the ports
  localparam int unsigned FIELD_W = 64;

  // division mode codes
  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  // control bits that travel with each request down the pipeline
  typedef struct packed {
    logic valid;
    logic q_neg;
    logic r_neg;
    logic den_zero;
  } rd64_ctl_t;

endpackage

### rtl/core/rd64_req_if.sv
`timescale 1ns / 1ps

interface rd64_req_if;
  import rd64_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, output mode, output dividend, output divisor, input ready);
  modport sink   (input valid, input mode, input dividend, input divisor, output ready);
endinterface

### rtl/core/rd64_rsp_if.sv
`timescale 1ns / 1ps

interface rd64_rsp_if;
  import rd64_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;
  logic [FIELD_W-1:0] remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

### rtl/core/rd64_step.sv
`timescale 1ns / 1ps

// one restoring shift-subtract iteration, registered
module rd64_step #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  rd64_pkg::rd64_ctl_t     ctl_in,
  input  logic [DATA_WIDTH-1:0]   rem_in,
  input  logic [DATA_WIDTH-1:0]   num_in,
  input  logic [DATA_WIDTH-1:0]   quo_in,
  input  logic [DATA_WIDTH-1:0]   den_in,
  output rd64_pkg::rd64_ctl_t     ctl_out,
  output logic [DATA_WIDTH-1:0]   rem_out,
  output logic [DATA_WIDTH-1:0]   num_out,
  output logic [DATA_WIDTH-1:0]   quo_out,
  output logic [DATA_WIDTH-1:0]   den_out
);
  import rd64_pkg::*;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] rem_next;

  // shift in the next dividend bit and trial-subtract the divisor;
  // partial remainder stays below the divisor, so bit W of diff is the borrow
  always_comb begin
    shifted  = {rem_in, num_in[DATA_WIDTH-1]};
    diff     = shifted - {1'b0, den_in};
    take     = ~diff[DATA_WIDTH];
    rem_next = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  end

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      num_out <= {num_in[DATA_WIDTH-2:0], 1'b0};
      quo_out <= {quo_in[DATA_WIDTH-2:0], take};
      den_out <= den_in;
    end
  end

endmodule

### rtl/core/restoring_divider_64.sv
`timescale 1ns / 1ps

// Pipelined restoring divider. Each request gives quotient and remainder of
// dividend / divisor, unsigned (mode 0) or signed two's complement (mode 1),
// using the low DATA_WIDTH bits of each operand; result upper bits are zero.
// Signed results truncate toward zero, the remainder follows the dividend's
// sign, and a zero divisor yields zero for both. A new request is taken every
// cycle unless a result waits on the response side. A request passes
// DATA_WIDTH + 2 register stages: one operand stage that takes magnitudes,
// one stage per quotient bit (one subtract each), and one output stage that
// restores signs. The whole pipeline holds while a result waits on the
// response side, so req.ready follows !rsp.valid || rsp.ready.
module restoring_divider_64 #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  rd64_req_if.sink   req,
  rd64_rsp_if.source rsp
);
  import rd64_pkg::*;

  logic en;

  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic                  a_neg;
  logic                  b_neg;
  rd64_ctl_t             ctl_first;

  rd64_ctl_t             ctl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] num [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] quo [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den [0:DATA_WIDTH];

  logic [DATA_WIDTH-1:0] quo_fix;
  logic [DATA_WIDTH-1:0] rem_fix;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_quo;
  logic [DATA_WIDTH-1:0] out_rem;

  // global advance: move whenever the output slot is free or being taken
  assign en        = ~out_valid | rsp.ready;
  assign req.ready = en;

  // operand magnitudes and sign bookkeeping
  always_comb begin
    a     = req.dividend[DATA_WIDTH-1:0];
    b     = req.divisor[DATA_WIDTH-1:0];
    a_neg = (req.mode == MODE_SIGNED) & a[DATA_WIDTH-1];
    b_neg = (req.mode == MODE_SIGNED) & b[DATA_WIDTH-1];
    ctl_first.valid    = req.valid;
    ctl_first.q_neg    = a_neg ^ b_neg;
    ctl_first.r_neg    = a_neg;
    ctl_first.den_zero = (b == '0);
  end

  // operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= ctl_first;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      num[0] <= a_neg ? (~a + 1'b1) : a;
      quo[0] <= '0;
      den[0] <= b_neg ? (~b + 1'b1) : b;
    end
  end

  // one stage per quotient bit, most significant first
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    rd64_step #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[i]),
      .rem_in  (rem[i]),
      .num_in  (num[i]),
      .quo_in  (quo[i]),
      .den_in  (den[i]),
      .ctl_out (ctl[i+1]),
      .rem_out (rem[i+1]),
      .num_out (num[i+1]),
      .quo_out (quo[i+1]),
      .den_out (den[i+1])
    );
  end

  // sign restore and zero-divisor override
  always_comb begin
    quo_fix = ctl[DATA_WIDTH].q_neg ? (~quo[DATA_WIDTH] + 1'b1) : quo[DATA_WIDTH];
    rem_fix = ctl[DATA_WIDTH].r_neg ? (~rem[DATA_WIDTH] + 1'b1) : rem[DATA_WIDTH];
    if (ctl[DATA_WIDTH].den_zero) begin
      quo_fix = '0;
      rem_fix = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl[DATA_WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quo <= quo_fix;
      out_rem <= rem_fix;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.quotient  = FIELD_W'(out_quo);
  assign rsp.remainder = FIELD_W'(out_rem);

  // request side stalls only under response backpressure
  assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (rsp.valid && !rsp.ready))
    else $error("request side stalled without response backpressure");

  // partial remainder at the last stage is below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (ctl[DATA_WIDTH].valid && !ctl[DATA_WIDTH].den_zero) |->
      (rem[DATA_WIDTH] < den[DATA_WIDTH]))
    else $error("final remainder not below divisor");

  // zero divisor gives zero results
  assert property (@(posedge clk) disable iff (rst)
    (en && ctl[DATA_WIDTH].valid && ctl[DATA_WIDTH].den_zero) |=>
      (rsp.valid && rsp.quotient == '0 && rsp.remainder == '0))
    else $error("zero divisor did not give zero results");

  // a held result keeps its value while the pipeline is frozen
  assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(out_quo) && $stable(out_rem) && $stable(ctl[DATA_WIDTH])))
    else $error("pipeline moved while stalled");

endmodule
